### rtl/core/lemd_pkg.sv
// shared types and constants for the light average and motion debounce block
package lemd_pkg;

  // field widths
  localparam int RAW_W   = 12;
  localparam int TS_W    = 32;
  localparam int NORM_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int AVG_W   = RAW_W + FRAC_W;
  localparam int ALPHA_W = FRAC_W + 1;
  localparam int DEB_W   = 16;
  localparam int CFG_W   = ALPHA_W;
  localparam int CFG_IDX_W = 1;

  // ema arithmetic
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << FRAC_W;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(13107);
  localparam logic [DEB_W-1:0]   DEB_RESET   = DEB_W'(50);
  localparam int                 PROD_W      = ALPHA_W + AVG_W;
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [AVG_W-1:0]   AVG_MAX     = AVG_W'((1 << RAW_W) - 1) << FRAC_W;

  // normalization: avg / 4095 as a multiply by a rounded-up reciprocal
  localparam int                NORM_DIV    = (1 << RAW_W) - 1;
  localparam int                NORM_SHIFT  = AVG_W + RAW_W;
  localparam logic [63:0]       NORM_RECIP_W =
    ((64'd1 << NORM_SHIFT) + 64'(NORM_DIV) - 64'd1) / 64'(NORM_DIV);
  localparam int                RECIP_W     = AVG_W + 1;
  localparam logic [RECIP_W-1:0] NORM_RECIP = NORM_RECIP_W[RECIP_W-1:0];
  localparam int                NPROD_W     = AVG_W + RECIP_W;
  localparam int                QUO_W       = NORM_W + 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_ALPHA = 1'b0,
    CFG_DEBOUNCE_MS = 1'b1
  } cfg_idx_t;

  // debounce result handed to the pipeline
  typedef struct packed {
    logic            stable;
    logic            changed;
    logic [TS_W-1:0] changed_at;
  } mot_res_t;

endpackage

### rtl/core/lemd_if.sv
// valid/ready channel interfaces for poll items and result items

interface lemd_in_if
  import lemd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] light_sample;
  logic             motion_level;
  logic [TS_W-1:0]  now_ms;

  modport source (output valid, light_sample, motion_level, now_ms, input ready);
  modport sink   (input valid, light_sample, motion_level, now_ms, output ready);
endinterface

interface lemd_out_if
  import lemd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  light_raw_out;
  logic [RAW_W-1:0]  light_filtered;
  logic [NORM_W-1:0] light_norm;
  logic              motion_stable;
  logic              motion_changed;
  logic [TS_W-1:0]   motion_changed_at_ms;

  modport source (output valid, light_raw_out, light_filtered, light_norm,
                  motion_stable, motion_changed, motion_changed_at_ms, input ready);
  modport sink   (input valid, light_raw_out, light_filtered, light_norm,
                  motion_stable, motion_changed, motion_changed_at_ms, output ready);
endinterface

### rtl/core/lemd_norm.sv
// average to q0.16 normalization by reciprocal multiply, saturated
module lemd_norm
  import lemd_pkg::*;
(
  input  logic [AVG_W-1:0]  avg,
  output logic [NORM_W-1:0] norm
);

  logic [NPROD_W-1:0] prod;
  logic [QUO_W-1:0]   quo;

  // exact floor(avg / 4095) over the whole average range
  assign prod = NPROD_W'(avg) * NPROD_W'(NORM_RECIP);
  assign quo  = prod[NORM_SHIFT +: QUO_W];
  // only full scale reaches 65536
  assign norm = quo[QUO_W-1] ? {NORM_W{1'b1}} : quo[NORM_W-1:0];

endmodule

### rtl/core/lemd_debounce.sv
// motion level debounce state and per-item decision
module lemd_debounce
  import lemd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             lvl,
  input  logic [TS_W-1:0]  now_ms,
  input  logic [DEB_W-1:0] debounce_ms,
  output mot_res_t         res
);

  logic            last_read_r;
  logic [TS_W-1:0] last_edge_r;
  logic            stable_r;
  logic [TS_W-1:0] change_at_r;

  logic            edge_seen;
  logic [TS_W-1:0] edge_ms;
  logic [TS_W-1:0] elapsed;
  logic            fire;

  always_comb begin
    edge_seen = lvl != last_read_r;
    edge_ms   = edge_seen ? now_ms : last_edge_r;
    elapsed   = now_ms - edge_ms;
    fire      = (elapsed >= TS_W'(debounce_ms)) && (stable_r != lvl);
    res.stable     = fire ? lvl : stable_r;
    res.changed    = fire;
    res.changed_at = fire ? now_ms : change_at_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_read_r <= 1'b0;
      last_edge_r <= '0;
      stable_r    <= 1'b0;
      change_at_r <= '0;
    end else if (step) begin
      last_read_r <= lvl;
      last_edge_r <= edge_ms;
      stable_r    <= res.stable;
      change_at_r <= res.changed_at;
    end
  end

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(stable_r) && $stable(change_at_r) && $stable(last_edge_r))
    else $error("debounce state moved without an item");

  a_change_flips: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.changed |=> stable_r != $past(stable_r))
    else $error("change flagged but stable level did not flip");

  a_change_time: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.changed |=> change_at_r == $past(now_ms))
    else $error("change time is not the item timestamp");

endmodule

### rtl/core/light_ema_and_motion_debounce.sv
// top level: light moving average with normalization and motion debounce
//
// One poll item per clock cycle, sustained while out_ch.ready keeps up. Items
// pass from acceptance to result through an input register, an update
// register that holds the new average and debounce decision, and a result
// register that adds the normalized light value. The rate is set by the
// average feedback loop, which runs through one 17 x 28 bit multiply and an
// add in a single cycle; the reciprocal multiply for normalization sits in
// the following stage. Each stage has its own valid bit and takes a new item
// whenever it is empty or its contents move on, so bubbles close up and input
// can still fill empty stages while a finished result waits on out_ch.ready.
// Configuration writes take effect on the next edge and are meant to happen
// only while no item is in flight. No clearing pass is needed after reset.
module light_ema_and_motion_debounce
  import lemd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // item channels
  lemd_in_if.sink              in_ch,
  lemd_out_if.source           out_ch
);

  // configuration registers
  logic [ALPHA_W-1:0] alpha_r;
  logic [DEB_W-1:0]   debounce_r;

  // stage 1: input register
  logic               s1_v_r;
  logic [RAW_W-1:0]   s1_raw_r;
  logic               s1_lvl_r;
  logic [TS_W-1:0]    s1_now_r;

  // running average state, q12.16
  logic [AVG_W-1:0]   avg_r;
  logic [AVG_W-1:0]   avg_nxt;

  // stage 2: update register
  logic               s2_v_r;
  logic [RAW_W-1:0]   s2_raw_r;
  logic [AVG_W-1:0]   s2_avg_r;
  mot_res_t           s2_mot_r;

  // stage 3: result register
  logic               out_v_r;
  logic [RAW_W-1:0]   out_raw_r;
  logic [RAW_W-1:0]   out_filt_r;
  logic [NORM_W-1:0]  out_norm_r;
  mot_res_t           out_mot_r;

  // handshake between stages
  logic s3_ready, s2_ready, s1_ready;
  logic s1_move, s2_move, in_take;

  // ema datapath
  logic [ALPHA_W-1:0]     a_sat;
  logic [ALPHA_W-1:0]     a_inv;
  logic [AVG_W:0]         new_term;
  logic [PROD_W-1:0]      old_term;
  logic [AVG_W+1:0]       avg_upd;

  mot_res_t           mot_nxt;
  logic [NORM_W-1:0]  norm_nxt;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= ALPHA_RESET;
      debounce_r <= DEB_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LIGHT_ALPHA: alpha_r    <= cfg_wdata;
        CFG_DEBOUNCE_MS: debounce_r <= cfg_wdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage handshake: a stage loads when empty or when its item moves on
  // ---------------------------------------------------------------------
  assign s3_ready = !out_v_r || out_ch.ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s2_move  = s2_v_r && s3_ready;
  assign s1_move  = s1_v_r && s2_ready;
  assign in_take  = in_ch.valid && s1_ready;

  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: capture the poll
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_ch.light_sample;
      s1_lvl_r <= in_ch.motion_level;
      s1_now_r <= in_ch.now_ms;
    end
  end

  // ---------------------------------------------------------------------
  // moving average update
  // the new-sample term is already at the average's scale, so only the
  // old-average term needs rounding before the shift
  // ---------------------------------------------------------------------
  always_comb begin
    // alpha above one behaves as one
    a_sat    = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    a_inv    = ALPHA_ONE - a_sat;
    new_term = (AVG_W + 1)'(a_sat) * (AVG_W + 1)'(s1_raw_r);
    old_term = PROD_W'(a_inv) * PROD_W'(avg_r) + ROUND_HALF;
    avg_upd  = (AVG_W + 2)'(new_term) + (AVG_W + 2)'(old_term[PROD_W-1:FRAC_W]);
    // a zero average is reseeded with the raw sample
    if (avg_r == '0) begin
      avg_nxt = {s1_raw_r, {FRAC_W{1'b0}}};
    end else begin
      avg_nxt = avg_upd[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (s1_move) begin
      avg_r <= avg_nxt;
    end
  end

  // motion debounce runs on the same item step as the average
  lemd_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_move),
    .lvl         (s1_lvl_r),
    .now_ms      (s1_now_r),
    .debounce_ms (debounce_r),
    .res         (mot_nxt)
  );

  // ---------------------------------------------------------------------
  // stage 2: hold the updated values
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_raw_r <= s1_raw_r;
      s2_avg_r <= avg_nxt;
      s2_mot_r <= mot_nxt;
    end
  end

  // normalization off the registered average
  lemd_norm u_norm (
    .avg  (s2_avg_r),
    .norm (norm_nxt)
  );

  // ---------------------------------------------------------------------
  // stage 3: result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_raw_r  <= s2_raw_r;
      out_filt_r <= s2_avg_r[AVG_W-1:FRAC_W];
      out_norm_r <= norm_nxt;
      out_mot_r  <= s2_mot_r;
    end
  end

  assign out_ch.valid                = out_v_r;
  assign out_ch.light_raw_out        = out_raw_r;
  assign out_ch.light_filtered       = out_filt_r;
  assign out_ch.light_norm           = out_norm_r;
  assign out_ch.motion_stable        = out_mot_r.stable;
  assign out_ch.motion_changed       = out_mot_r.changed;
  assign out_ch.motion_changed_at_ms = out_mot_r.changed_at;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= AVG_MAX)
    else $error("average above full scale");

  a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(avg_r))
    else $error("average moved without an item");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> s2_v_r && s2_avg_r == avg_r)
    else $error("update stage lost an item or disagrees with the average");

endmodule
